// ===== hw/rtl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON byte tokenizer package
// Shared constants, character codes, token kinds and result types.
// ----------------------------------------------------------------------------
package jbt_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [3:0] KIND_CONTENT  = 4'd0;
   localparam logic [3:0] KIND_STRING   = 4'd1;
   localparam logic [3:0] KIND_INTEGER  = 4'd2;
   localparam logic [3:0] KIND_FLOAT    = 4'd3;
   localparam logic [3:0] KIND_LBRACE   = 4'd4;
   localparam logic [3:0] KIND_RBRACE   = 4'd5;
   localparam logic [3:0] KIND_LBRACKET = 4'd6;
   localparam logic [3:0] KIND_RBRACKET = 4'd7;
   localparam logic [3:0] KIND_COLON    = 4'd8;
   localparam logic [3:0] KIND_COMMA    = 4'd9;
   localparam logic [3:0] KIND_END      = 4'd10;
   localparam logic [3:0] KIND_INVALID  = 4'd11;

   // character codes
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_POINT    = 8'h2E;
   localparam logic [7:0] CHAR_0        = 8'h30;
   localparam logic [7:0] CHAR_9        = 8'h39;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_E  = 8'h45;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_LOWER_E  = 8'h65;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;

   typedef logic [POSITION_WIDTH-1:0] position_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  content_byte;
      logic [15:0] token_row;
      logic [15:0] token_column;
      logic        last_result;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

   // place a counter into a 16-bit output field
   function automatic logic [15:0] to_field(input position_type v);
      logic [31:0] ext;
      ext = 32'(v);
      return ext[15:0];
   endfunction

   function automatic position_type sat_inc(input position_type v);
      return (v == POS_MAX) ? v : v + position_type'(1);
   endfunction

   // punctuation kind, KIND_CONTENT when the byte is no punctuation
   function automatic logic [3:0] punct_kind(input logic [7:0] b);
      logic [3:0] k;
      case (b)
         CHAR_LBRACE:   k = KIND_LBRACE;
         CHAR_RBRACE:   k = KIND_RBRACE;
         CHAR_LBRACKET: k = KIND_LBRACKET;
         CHAR_RBRACKET: k = KIND_RBRACKET;
         CHAR_COLON:    k = KIND_COLON;
         CHAR_COMMA:    k = KIND_COMMA;
         default:       k = KIND_CONTENT;
      endcase
      return k;
   endfunction

   function automatic logic num_start(input logic [7:0] b);
      return (b inside {[CHAR_0:CHAR_9], CHAR_MINUS, CHAR_PLUS});
   endfunction

   function automatic logic num_body(input logic [7:0] b);
      return num_start(b) || (b inside {CHAR_POINT, CHAR_UPPER_E, CHAR_LOWER_E});
   endfunction

   function automatic result_type make_result(input logic [3:0] kind,
                                              input logic [7:0] content,
                                              input position_type row,
                                              input position_type col);
      result_type r;
      r.kind         = kind;
      r.content_byte = content;
      r.token_row    = to_field(row);
      r.token_column = to_field(col);
      r.last_result  = 1'b0;
      return r;
   endfunction

endpackage

// ===== hw/rtl/jbt_step.sv =====
// ----------------------------------------------------------------------------
// JSON byte tokenizer step
// Input register, lexer state and the per-byte decision producing up to two
// results for the output queue.
// ----------------------------------------------------------------------------
module jbt_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_eoi,
   output logic              in_ready,
   input  logic              room,
   output jbt_pkg::push_type push
);

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_STRING = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;

   logic                   held_ff;
   logic [7:0]             byte_ff;
   logic                   eoi_ff;

   logic [1:0]             mode_ff, mode_in;
   jbt_pkg::position_type  line_ff, line_in;
   jbt_pkg::position_type  col_ff, col_in;
   jbt_pkg::position_type  start_ff, start_in;
   logic                   saw_ff, saw_in;

   jbt_pkg::result_type    res [2];
   logic [1:0]             n;
   logic                   idle_pass;
   logic [3:0]             pk;
   logic [3:0]             num_kind;
   logic                   fire;

   assign fire     = held_ff && room;
   assign in_ready = !held_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else if (in_ready) begin
         held_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         eoi_ff  <= in_eoi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= jbt_pkg::position_type'(1);
         col_ff   <= jbt_pkg::position_type'(1);
         start_ff <= '0;
         saw_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         start_ff <= start_in;
         saw_ff   <= saw_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      start_in  = start_ff;
      saw_in    = saw_ff;
      res[0]    = '0;
      res[1]    = '0;
      n         = 2'd0;
      idle_pass = 1'b0;
      pk        = jbt_pkg::punct_kind(byte_ff);
      num_kind  = saw_ff ? jbt_pkg::KIND_FLOAT : jbt_pkg::KIND_INTEGER;

      if (eoi_ff) begin
         // close an open token, then the end token
         if (mode_ff == MODE_STRING) begin
            res[n[0]] = jbt_pkg::make_result(jbt_pkg::KIND_STRING, 8'd0, line_ff, start_ff);
            n = n + 2'd1;
         end else if (mode_ff == MODE_NUMBER) begin
            res[n[0]] = jbt_pkg::make_result(num_kind, 8'd0, line_ff, start_ff);
            n = n + 2'd1;
         end
         mode_in   = MODE_IDLE;
         res[n[0]] = jbt_pkg::make_result(jbt_pkg::KIND_END, 8'd0, line_ff, '0);
         n = n + 2'd1;
      end else begin
         case (mode_ff)
            MODE_STRING: begin
               if (byte_ff == jbt_pkg::CHAR_QUOTE) begin
                  res[0]  = jbt_pkg::make_result(jbt_pkg::KIND_STRING, 8'd0, line_ff,
                                                 start_ff);
                  mode_in = MODE_IDLE;
               end else begin
                  res[0] = jbt_pkg::make_result(jbt_pkg::KIND_CONTENT, byte_ff, line_ff,
                                                start_ff);
               end
               n      = 2'd1;
               col_in = jbt_pkg::sat_inc(col_ff);
            end
            MODE_NUMBER: begin
               if (jbt_pkg::num_body(byte_ff)) begin
                  res[0] = jbt_pkg::make_result(jbt_pkg::KIND_CONTENT, byte_ff, line_ff,
                                                start_ff);
                  n      = 2'd1;
                  if (byte_ff == jbt_pkg::CHAR_POINT) begin
                     saw_in = 1'b1;
                  end
                  col_in = jbt_pkg::sat_inc(col_ff);
               end else begin
                  // close the number, then treat the byte as in idle mode
                  res[0]    = jbt_pkg::make_result(num_kind, 8'd0, line_ff, start_ff);
                  n         = 2'd1;
                  idle_pass = 1'b1;
               end
            end
            default: begin
               idle_pass = 1'b1;
            end
         endcase

         if (idle_pass) begin
            mode_in = MODE_IDLE;
            if (byte_ff == jbt_pkg::CHAR_NEWLINE) begin
               line_in = jbt_pkg::sat_inc(line_ff);
               col_in  = jbt_pkg::position_type'(1);
            end else if (byte_ff inside {jbt_pkg::CHAR_TAB, jbt_pkg::CHAR_CR,
                                         jbt_pkg::CHAR_SPACE}) begin
               col_in = jbt_pkg::sat_inc(col_ff);
            end else if (pk != jbt_pkg::KIND_CONTENT) begin
               res[n[0]] = jbt_pkg::make_result(pk, 8'd0, line_ff, col_ff);
               n         = n + 2'd1;
               col_in    = jbt_pkg::sat_inc(col_ff);
            end else if (byte_ff == jbt_pkg::CHAR_QUOTE) begin
               start_in = col_ff;
               col_in   = jbt_pkg::sat_inc(col_ff);
               mode_in  = MODE_STRING;
            end else if (jbt_pkg::num_start(byte_ff)) begin
               start_in  = col_ff;
               saw_in    = 1'b0;
               res[n[0]] = jbt_pkg::make_result(jbt_pkg::KIND_CONTENT, byte_ff, line_ff,
                                                col_ff);
               n         = n + 2'd1;
               col_in    = jbt_pkg::sat_inc(col_ff);
               mode_in   = MODE_NUMBER;
            end else begin
               res[n[0]] = jbt_pkg::make_result(jbt_pkg::KIND_INVALID, 8'd0, line_ff,
                                                col_ff);
               n         = n + 2'd1;
               col_in    = jbt_pkg::sat_inc(col_ff);
            end
         end
      end

      // mark the final result of this byte
      res[0].last_result = (n == 2'd1);
      res[1].last_result = (n == 2'd2);

      push.count = fire ? n : 2'd0;
      push.res0  = res[0];
      push.res1  = res[1];
   end

endmodule

// ===== hw/rtl/jbt_out_queue.sv =====
// ----------------------------------------------------------------------------
// JSON byte tokenizer result queue
// Small queue taking up to two results per cycle and delivering one while out_ready is high.
// ----------------------------------------------------------------------------
module jbt_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  jbt_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output jbt_pkg::result_type out_result
);

   jbt_pkg::result_type                 entries_ff [jbt_pkg::QUEUE_DEPTH];
   logic [jbt_pkg::QUEUE_PTR_WIDTH-1:0] head_ff, head_in;
   logic [jbt_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic [jbt_pkg::QUEUE_PTR_WIDTH-1:0] tail;
   logic [jbt_pkg::QUEUE_PTR_WIDTH-1:0] tail_next;
   logic                                pop;

   assign tail      = head_ff + count_ff[jbt_pkg::QUEUE_PTR_WIDTH-1:0];
   assign tail_next = tail + jbt_pkg::QUEUE_PTR_WIDTH'(1);
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_result = entries_ff[head_ff];

   // room for a full pair, whatever leaves this cycle
   assign room = (count_ff <= jbt_pkg::QUEUE_CNT_WIDTH'(jbt_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      head_in  = pop ? head_ff + jbt_pkg::QUEUE_PTR_WIDTH'(1) : head_ff;
      count_in = count_ff + jbt_pkg::QUEUE_CNT_WIDTH'(push.count)
                 - jbt_pkg::QUEUE_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[tail] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entries_ff[tail_next] <= push.res1;
      end
   end

endmodule

// ===== hw/rtl/json_byte_tokenizer_core.sv =====
// rsp_tvalid rises once a byte has passed the input register and then the result queue.
// Throughput: one byte per cycle while the result queue has room for a pair; a byte
// yielding two results delivers them one at a time on the single-result output port.
// Reset: synchronous, active high; mode idle, row and column 1, result queue empty.
// ----------------------------------------------------------------------------
// JSON byte tokenizer core
// Streams JSON text bytes in and tokens with row and column positions out.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] content_byte, [23:8] token_row,
                                    // [39:24] token_column
   output logic [3:0]  rsp_tuser,   // [3:0] kind
   output logic        rsp_tlast    // last_result
);

   jbt_pkg::push_type   push;
   jbt_pkg::result_type result;
   logic                room;

   jbt_step u_step (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_eoi   (req_tuser[0]),
      .in_ready (req_tready),
      .room     (room),
      .push     (push)
   );

   jbt_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.token_column, result.token_row, result.content_byte};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last_result;

endmodule
